// ===== rtl/core/whp_pkg.sv =====
// Shared constants and command/status types for the WAV header parser.
`timescale 1ns / 1ps

package whp_pkg;

  localparam logic [31:0] TAG_RIFF    = 32'h4646_4952;
  localparam logic [31:0] TAG_WAVE    = 32'h4556_4157;
  localparam logic [31:0] TAG_FMT     = 32'h2074_6D66;
  localparam logic [31:0] TAG_DATA    = 32'h6174_6164;
  localparam logic [15:0] FMT_PCM     = 16'h0001;
  localparam logic [15:0] PCM_BITS    = 16'd16;
  localparam logic [31:0] FMT_MIN_LEN = 32'd16;

  localparam logic [3:0] ST_OK        = 4'd0;
  localparam logic [3:0] ST_TRUNC     = 4'd1;
  localparam logic [3:0] ST_NO_RIFF   = 4'd2;
  localparam logic [3:0] ST_NO_WAVE   = 4'd3;
  localparam logic [3:0] ST_NO_FMT    = 4'd4;
  localparam logic [3:0] ST_FMT_SHORT = 4'd5;
  localparam logic [3:0] ST_NOT_PCM16 = 4'd6;
  localparam logic [3:0] ST_NO_DATA   = 4'd7;
  localparam logic [3:0] ST_ZERO_CH   = 4'd8;

  typedef struct packed {
    logic       rearm;
    logic       take;
    logic       shift_word;
    logic       load_fmt_len;
    logic       body_write;
    logic       load_skip;
    logic       skip_dec;
    logic       load_result;
    logic [3:0] code;
    logic       start_div;
    logic       div_step;
  } whp_cmd_t;

  typedef struct packed {
    logic word_done;
    logic is_riff;
    logic is_wave;
    logic is_fmt;
    logic is_data;
    logic fmt_short;
    logic body_last;
    logic pcm_ok;
    logic skip_none;
    logic skip_last;
    logic chan_zero;
    logic div_last;
  } whp_stat_t;

endpackage

// ===== rtl/core/whp_in_if.sv =====
// Byte stream channel carrying one file byte and its end-of-file mark per beat.
`timescale 1ns / 1ps

interface whp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

// ===== rtl/core/whp_out_if.sv =====
// Header report channel carrying the parse status and the decoded header fields.
`timescale 1ns / 1ps

interface whp_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  status;
  logic [15:0] channel_total;
  logic [31:0] rate_hz;
  logic [30:0] total_frames;
  logic [31:0] data_offset;

  modport source (output valid, output status, output channel_total, output rate_hz,
                  output total_frames, output data_offset, input ready);
  modport sink (input valid, input status, input channel_total, input rate_hz,
                input total_frames, input data_offset, output ready);
endinterface

// ===== rtl/core/whp_ctrl.sv =====
// Controller of the WAV header parser: parse phase, report flag and flow control.
`timescale 1ns / 1ps

module whp_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               last_byte,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  whp_pkg::whp_stat_t stat,
  output whp_pkg::whp_cmd_t  cmd
);
  import whp_pkg::*;

  typedef enum logic [8:0] {
    PH_RIFF    = 9'b000000001,
    PH_RSIZE   = 9'b000000010,
    PH_WAVE    = 9'b000000100,
    PH_FMTTAG  = 9'b000001000,
    PH_FMTLEN  = 9'b000010000,
    PH_FMTBODY = 9'b000100000,
    PH_SKIP    = 9'b001000000,
    PH_DATATAG = 9'b010000000,
    PH_DATALEN = 9'b100000000
  } phase_t;

  typedef enum logic [1:0] {
    FL_RUN = 2'b01,
    FL_DIV = 2'b10
  } flow_t;

  phase_t phase, phase_next;
  flow_t  flow, flow_next;
  logic   reported, reported_next;
  logic   out_valid_next;
  logic   fire;

  assign in_ready = (flow == FL_RUN) && (!out_valid || reported);
  assign fire     = in_valid && in_ready;

  always_comb begin
    logic       hit;
    logic       good;
    logic [3:0] code;
    hit            = 1'b0;
    good           = 1'b0;
    code           = ST_OK;
    cmd            = '0;
    phase_next     = phase;
    flow_next      = flow;
    reported_next  = reported;
    out_valid_next = out_valid;

    if (out_valid && out_ready) begin
      out_valid_next = 1'b0;
    end

    if (flow == FL_DIV) begin
      cmd.div_step = 1'b1;
      if (stat.div_last) begin
        flow_next      = FL_RUN;
        out_valid_next = 1'b1;
      end
    end

    if (fire) begin
      if (!reported) begin
        cmd.take = 1'b1;
        unique case (phase)
          PH_RSIZE: begin
            cmd.shift_word = 1'b1;
            if (stat.word_done) begin
              phase_next = PH_WAVE;
            end
          end
          PH_WAVE: begin
            cmd.shift_word = 1'b1;
            if (stat.word_done) begin
              if (stat.is_wave) begin
                phase_next = PH_FMTTAG;
              end else begin
                hit  = 1'b1;
                code = ST_NO_WAVE;
              end
            end
          end
          PH_FMTTAG: begin
            cmd.shift_word = 1'b1;
            if (stat.word_done) begin
              if (stat.is_fmt) begin
                phase_next = PH_FMTLEN;
              end else begin
                hit  = 1'b1;
                code = ST_NO_FMT;
              end
            end
          end
          PH_FMTLEN: begin
            cmd.shift_word = 1'b1;
            if (stat.word_done) begin
              if (stat.fmt_short) begin
                hit  = 1'b1;
                code = ST_FMT_SHORT;
              end else begin
                cmd.load_fmt_len = 1'b1;
                phase_next       = PH_FMTBODY;
              end
            end
          end
          PH_FMTBODY: begin
            cmd.body_write = 1'b1;
            if (stat.body_last) begin
              if (!stat.pcm_ok) begin
                hit  = 1'b1;
                code = ST_NOT_PCM16;
              end else if (stat.skip_none) begin
                phase_next = PH_DATATAG;
              end else begin
                cmd.load_skip = 1'b1;
                phase_next    = PH_SKIP;
              end
            end
          end
          PH_SKIP: begin
            cmd.skip_dec = 1'b1;
            if (stat.skip_last) begin
              phase_next = PH_DATATAG;
            end
          end
          PH_DATATAG: begin
            cmd.shift_word = 1'b1;
            if (stat.word_done) begin
              if (stat.is_data) begin
                phase_next = PH_DATALEN;
              end else begin
                hit  = 1'b1;
                code = ST_NO_DATA;
              end
            end
          end
          PH_DATALEN: begin
            cmd.shift_word = 1'b1;
            if (stat.word_done) begin
              hit = 1'b1;
              if (stat.chan_zero) begin
                code = ST_ZERO_CH;
              end else begin
                good = 1'b1;
              end
            end
          end
          default: begin
            cmd.shift_word = 1'b1;
            phase_next     = PH_RIFF;
            if (stat.word_done) begin
              if (stat.is_riff) begin
                phase_next = PH_RSIZE;
              end else begin
                hit  = 1'b1;
                code = ST_NO_RIFF;
              end
            end
          end
        endcase

        if (!hit && last_byte) begin
          hit  = 1'b1;
          code = ST_TRUNC;
        end

        if (hit) begin
          reported_next = 1'b1;
          if (good) begin
            cmd.start_div = 1'b1;
            flow_next     = FL_DIV;
          end else begin
            cmd.load_result = 1'b1;
            cmd.code        = code;
            out_valid_next  = 1'b1;
          end
        end
      end

      if (last_byte) begin
        cmd.rearm     = 1'b1;
        phase_next    = PH_RIFF;
        reported_next = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_RIFF;
      flow      <= FL_RUN;
      reported  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      phase     <= phase_next;
      flow      <= flow_next;
      reported  <= reported_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

// ===== rtl/core/whp_dp.sv =====
// Datapath of the WAV header parser: field assembly, counters, divider and report fields.
`timescale 1ns / 1ps

module whp_dp (
  input  logic               clk,
  input  logic               rst,
  input  logic [7:0]         data_byte,
  input  whp_pkg::whp_cmd_t  cmd,
  output whp_pkg::whp_stat_t stat,
  output logic [3:0]         status,
  output logic [15:0]        channel_total,
  output logic [31:0]        rate_hz,
  output logic [30:0]        total_frames,
  output logic [31:0]        data_offset
);
  import whp_pkg::*;

  logic [31:0] field_shift;
  logic [1:0]  field_byte_index;
  logic [31:0] fmt_length;
  logic [31:0] skip_remaining;
  logic [3:0]  body_ofs;
  logic [15:0] format_code;
  logic [15:0] bits_field;
  logic [15:0] channels_held;
  logic [31:0] rate_held;
  logic [31:0] byte_position;
  logic [31:0] word_next;
  logic [31:0] position_next;
  logic [16:0] divisor;
  logic [16:0] rem;
  logic [31:0] quo;
  logic [4:0]  div_cnt;
  logic [17:0] rem_shift;
  logic        rem_ge;

  assign word_next     = {data_byte, field_shift[31:8]};
  assign position_next = (byte_position == '1) ? byte_position : byte_position + 32'd1;
  assign rem_shift     = {rem, quo[31]};
  assign rem_ge        = rem_shift >= {1'b0, divisor};

  assign stat.word_done = field_byte_index == 2'd3;
  assign stat.is_riff   = word_next == TAG_RIFF;
  assign stat.is_wave   = word_next == TAG_WAVE;
  assign stat.is_fmt    = word_next == TAG_FMT;
  assign stat.is_data   = word_next == TAG_DATA;
  assign stat.fmt_short = word_next < FMT_MIN_LEN;
  assign stat.body_last = body_ofs == 4'd15;
  assign stat.pcm_ok    = (format_code == FMT_PCM) && ({data_byte, bits_field[7:0]} == PCM_BITS);
  assign stat.skip_none = fmt_length == FMT_MIN_LEN;
  assign stat.skip_last = skip_remaining == 32'd1;
  assign stat.chan_zero = channels_held == 16'd0;
  assign stat.div_last  = div_cnt == 5'd31;

  assign total_frames = quo[30:0];

  always_ff @(posedge clk) begin
    if (rst || cmd.rearm) begin
      byte_position    <= 32'd0;
      field_byte_index <= 2'd0;
    end else begin
      if (cmd.take) begin
        byte_position <= position_next;
      end
      if (cmd.shift_word) begin
        field_byte_index <= field_byte_index + 2'd1;
      end
    end
    if (cmd.shift_word) begin
      field_shift <= word_next;
    end
    if (cmd.load_fmt_len) begin
      fmt_length <= word_next;
      body_ofs   <= 4'd0;
    end
    if (cmd.body_write) begin
      body_ofs <= body_ofs + 4'd1;
      case (body_ofs)
        4'd0:    format_code[7:0]    <= data_byte;
        4'd1:    format_code[15:8]   <= data_byte;
        4'd2:    channels_held[7:0]  <= data_byte;
        4'd3:    channels_held[15:8] <= data_byte;
        4'd4:    rate_held[7:0]      <= data_byte;
        4'd5:    rate_held[15:8]     <= data_byte;
        4'd6:    rate_held[23:16]    <= data_byte;
        4'd7:    rate_held[31:24]    <= data_byte;
        4'd14:   bits_field[7:0]     <= data_byte;
        4'd15:   bits_field[15:8]    <= data_byte;
        default: ;
      endcase
    end
    if (cmd.load_skip) begin
      skip_remaining <= fmt_length - FMT_MIN_LEN;
    end
    if (cmd.skip_dec) begin
      skip_remaining <= skip_remaining - 32'd1;
    end
    if (cmd.load_result) begin
      status        <= cmd.code;
      channel_total <= 16'd0;
      rate_hz       <= 32'd0;
      data_offset   <= 32'd0;
      quo           <= 32'd0;
    end
    if (cmd.start_div) begin
      status        <= ST_OK;
      channel_total <= channels_held;
      rate_hz       <= rate_held;
      data_offset   <= position_next;
      quo           <= word_next;
      rem           <= 17'd0;
      divisor       <= {channels_held, 1'b0};
      div_cnt       <= 5'd0;
    end
    if (cmd.div_step) begin
      rem     <= rem_ge ? 17'(rem_shift - {1'b0, divisor}) : rem_shift[16:0];
      quo     <= {quo[30:0], rem_ge};
      div_cnt <= div_cnt + 5'd1;
    end
  end

endmodule

// ===== rtl/core/wav_header_parser.sv =====
// Top level of the WAV header parser: byte channel in, one header report per file out.
// Takes one byte per cycle while not stalled. An error report is valid in the cycle after the
// byte that causes it; a good report follows the last data-size byte once the 32-step divider
// that produces total_frames has finished, during which no byte is taken.
// A report that waits holds off the first byte of the next file until it is taken.
// Synchronous reset clears the parse phase, the report flag, the byte counters and the output valid.
`timescale 1ns / 1ps

module wav_header_parser (
  input logic      clk,
  input logic      rst,
  whp_in_if.sink   stream,
  whp_out_if.source header
);
  import whp_pkg::*;

  whp_cmd_t  cmd;
  whp_stat_t stat;

  whp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (stream.valid),
    .last_byte (stream.last_byte),
    .in_ready  (stream.ready),
    .out_valid (header.valid),
    .out_ready (header.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  whp_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .data_byte     (stream.data_byte),
    .cmd           (cmd),
    .stat          (stat),
    .status        (header.status),
    .channel_total (header.channel_total),
    .rate_hz       (header.rate_hz),
    .total_frames  (header.total_frames),
    .data_offset   (header.data_offset)
  );

endmodule

// ===== test/wav_header_parser_tb.sv =====
// Self-checking testbench that streams WAV files byte by byte and checks each header report.
`timescale 1ns / 1ps

module wav_header_parser_tb;
  import whp_pkg::*;

  localparam int CYCLE_LIMIT = 200000;

  typedef enum logic [3:0] {
    HUNT_RIFF, RIFF_SIZE, HUNT_WAVE, HUNT_FMT, FMT_SIZE,
    FMT_BODY, FMT_EXTRA, HUNT_DATA, DATA_SIZE
  } hdr_phase_t;

  typedef enum int {BAD_NONE, BAD_RIFF, BAD_WAVE, BAD_FMT, BAD_DATA} bad_tag_t;

  typedef struct packed {
    logic [3:0]  status;
    logic [15:0] chans;
    logic [31:0] rate;
    logic [30:0] frames;
    logic [31:0] offset;
  } report_t;

  typedef struct {
    logic [7:0] b;
    logic       last;
    bit         drain;
  } file_byte_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  whp_in_if  byte_ch ();
  whp_out_if report_ch ();

  wav_header_parser dut (
    .clk    (clk),
    .rst    (rst),
    .stream (byte_ch),
    .header (report_ch)
  );

  always #4 clk = ~clk;

  file_byte_t file_bytes[$];
  report_t    due_reports[$];
  file_byte_t cur_byte;

  hdr_phase_t  ph;
  logic [1:0]  word_cnt;
  logic [31:0] word_q;
  logic [31:0] fmt_size;
  logic [31:0] left_cnt;
  logic [15:0] fmt_code_q;
  logic [15:0] bits_q;
  logic [15:0] chans_q;
  logic [31:0] rate_q;
  logic [31:0] pos_q;
  logic        reported;

  int errors = 0;
  int cycles = 0;
  int bytes_taken = 0;
  int bytes_queued = 0;
  int files_queued = 0;
  int good_seen = 0;
  int bad_seen = 0;
  int send_gap = 0;
  int send_calm = 0;
  int rcv_gap = 0;
  int rcv_calm = 0;
  bit held_long = 1'b0;

  function automatic void rearm();
    ph = HUNT_RIFF;
    word_cnt = '0;
    word_q = '0;
    fmt_size = '0;
    left_cnt = '0;
    fmt_code_q = '0;
    bits_q = '0;
    chans_q = '0;
    rate_q = '0;
    pos_q = '0;
    reported = 1'b0;
  endfunction

  function automatic bit shift_word(input logic [7:0] b);
    word_q = {b, word_q[31:8]};
    word_cnt = word_cnt + 2'd1;
    return word_cnt == 2'd0;
  endfunction

  function automatic void parse_byte(input logic [7:0] b, input logic last);
    bit          hit;
    logic [3:0]  st;
    logic [31:0] frames;
    logic [31:0] offs;
    int          o;
    report_t     r;
    hit = 1'b0;
    st = ST_OK;
    frames = '0;
    offs = '0;
    if (!reported) begin
      if (pos_q != 32'hFFFF_FFFF) pos_q++;
      case (ph)
        RIFF_SIZE: if (shift_word(b)) ph = HUNT_WAVE;
        HUNT_WAVE: if (shift_word(b)) begin
          if (word_q != TAG_WAVE) begin
            hit = 1'b1;
            st = ST_NO_WAVE;
          end else ph = HUNT_FMT;
        end
        HUNT_FMT: if (shift_word(b)) begin
          if (word_q != TAG_FMT) begin
            hit = 1'b1;
            st = ST_NO_FMT;
          end else ph = FMT_SIZE;
        end
        FMT_SIZE: if (shift_word(b)) begin
          fmt_size = word_q;
          if (fmt_size < FMT_MIN_LEN) begin
            hit = 1'b1;
            st = ST_FMT_SHORT;
          end else begin
            left_cnt = FMT_MIN_LEN;
            ph = FMT_BODY;
          end
        end
        FMT_BODY: begin
          if (left_cnt == 0 || left_cnt > FMT_MIN_LEN) left_cnt = FMT_MIN_LEN;
          o = 16 - int'(left_cnt);
          case (o)
            0: fmt_code_q[7:0] = b;
            1: fmt_code_q[15:8] = b;
            2: chans_q[7:0] = b;
            3: chans_q[15:8] = b;
            4, 5, 6, 7: rate_q[8*(o-4) +: 8] = b;
            14: bits_q[7:0] = b;
            15: bits_q[15:8] = b;
            default: ;
          endcase
          left_cnt--;
          if (left_cnt == 0) begin
            if (fmt_code_q != FMT_PCM || bits_q != PCM_BITS) begin
              hit = 1'b1;
              st = ST_NOT_PCM16;
            end else begin
              left_cnt = fmt_size - FMT_MIN_LEN;
              ph = (left_cnt != 0) ? FMT_EXTRA : HUNT_DATA;
            end
          end
        end
        FMT_EXTRA: begin
          if (left_cnt != 0) left_cnt--;
          if (left_cnt == 0) ph = HUNT_DATA;
        end
        HUNT_DATA: if (shift_word(b)) begin
          if (word_q != TAG_DATA) begin
            hit = 1'b1;
            st = ST_NO_DATA;
          end else ph = DATA_SIZE;
        end
        DATA_SIZE: if (shift_word(b)) begin
          hit = 1'b1;
          if (chans_q == 0) begin
            st = ST_ZERO_CH;
          end else begin
            st = ST_OK;
            frames = word_q / {15'd0, chans_q, 1'b0};
            offs = pos_q;
          end
        end
        default: begin
          ph = HUNT_RIFF;
          if (shift_word(b)) begin
            if (word_q != TAG_RIFF) begin
              hit = 1'b1;
              st = ST_NO_RIFF;
            end else ph = RIFF_SIZE;
          end
        end
      endcase
      if (!hit && last) begin
        hit = 1'b1;
        st = ST_TRUNC;
      end
    end
    if (hit) begin
      reported = 1'b1;
      r = '0;
      r.status = st;
      if (st == ST_OK) begin
        r.chans = chans_q;
        r.rate = rate_q;
        r.frames = frames[30:0];
        r.offset = offs;
      end
      due_reports.push_back(r);
    end
    if (last) rearm();
  endfunction

  function automatic int draw_gap(ref int calm);
    int g;
    if (calm > 0) begin
      calm--;
      g = 0;
    end else begin
      g = $urandom_range(0, 11);
      if ($urandom_range(0, 15) == 0) calm = $urandom_range(8, 48);
    end
    return g;
  endfunction

  function automatic void put_le(ref logic [7:0] f[$], input logic [31:0] v, input int n);
    for (int i = 0; i < n; i++) f.push_back(v[8*i +: 8]);
  endfunction

  function automatic void push_file(ref logic [7:0] f[$], input bit drain);
    for (int i = 0; i < f.size(); i++)
      file_bytes.push_back('{f[i], i == f.size() - 1, drain && i == 0});
    bytes_queued += f.size();
    files_queued++;
  endfunction

  function automatic void add_file(input logic [31:0] fmt_len, input logic [15:0] code,
                                   input logic [15:0] chans, input logic [31:0] rate,
                                   input logic [15:0] bits, input logic [31:0] dsize,
                                   input int tail, input int cut, input bad_tag_t bad,
                                   input bit drain);
    logic [7:0] f[$];
    int extra;
    int at;
    extra = 0;
    if (fmt_len >= 32'd16) extra = (fmt_len - 32'd16 > 32'd48) ? 48 : int'(fmt_len - 32'd16);
    put_le(f, TAG_RIFF, 4);
    put_le(f, $urandom, 4);
    put_le(f, TAG_WAVE, 4);
    put_le(f, TAG_FMT, 4);
    put_le(f, fmt_len, 4);
    put_le(f, 32'(code), 2);
    put_le(f, 32'(chans), 2);
    put_le(f, rate, 4);
    put_le(f, $urandom, 4);
    put_le(f, $urandom, 2);
    put_le(f, 32'(bits), 2);
    for (int i = 0; i < extra; i++) f.push_back(8'($urandom));
    put_le(f, TAG_DATA, 4);
    put_le(f, dsize, 4);
    for (int i = 0; i < tail; i++) f.push_back(8'($urandom));
    case (bad)
      BAD_RIFF: at = 0;
      BAD_WAVE: at = 8;
      BAD_FMT:  at = 12;
      BAD_DATA: at = 36 + extra;
      default:  at = -1;
    endcase
    if (at >= 0) begin
      at += $urandom_range(0, 3);
      f[at] = f[at] ^ (8'd1 << $urandom_range(0, 7));
    end
    if (cut >= 0 && cut < f.size() - 1) f = f[0:cut];
    push_file(f, drain);
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      errors++;
    end
  endfunction

  // Byte driver: the first byte of a file marked for draining waits for all reports.
  always @(posedge clk) begin
    if (rst) begin
      byte_ch.valid <= 1'b0;
      byte_ch.data_byte <= '0;
      byte_ch.last_byte <= 1'b0;
      send_gap = 0;
      rearm();
    end else begin
      if (byte_ch.valid && byte_ch.ready) begin
        parse_byte(byte_ch.data_byte, byte_ch.last_byte);
        bytes_taken++;
      end
      if (!byte_ch.valid || byte_ch.ready) begin
        if (send_gap > 0) begin
          send_gap--;
          byte_ch.valid <= 1'b0;
        end else if (file_bytes.size() != 0 &&
                     !(file_bytes[0].drain && due_reports.size() != 0)) begin
          cur_byte = file_bytes.pop_front();
          byte_ch.valid <= 1'b1;
          byte_ch.data_byte <= cur_byte.b;
          byte_ch.last_byte <= cur_byte.last;
          send_gap = draw_gap(send_calm);
        end else begin
          byte_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Report monitor: one long hold-off lets the parser back up and stall the byte stream.
  always @(posedge clk) begin
    if (rst) begin
      report_ch.ready <= 1'b0;
      rcv_gap = 0;
    end else begin
      if (report_ch.valid && report_ch.ready) begin
        if (due_reports.size() == 0) begin
          $error("report with no expectation: status %0d", report_ch.status);
          errors++;
        end else begin
          check_field("status", 32'(due_reports[0].status), 32'(report_ch.status));
          check_field("channel_total", 32'(due_reports[0].chans),
                      32'(report_ch.channel_total));
          check_field("rate_hz", due_reports[0].rate, report_ch.rate_hz);
          check_field("total_frames", 32'(due_reports[0].frames),
                      32'(report_ch.total_frames));
          check_field("data_offset", due_reports[0].offset, report_ch.data_offset);
          if (due_reports[0].status == ST_OK) good_seen++;
          else bad_seen++;
          void'(due_reports.pop_front());
        end
        rcv_gap = draw_gap(rcv_calm);
        if (!held_long && bytes_taken >= 300) begin
          rcv_gap = 400;
          held_long = 1'b1;
        end
      end else if (rcv_gap > 0) begin
        rcv_gap--;
      end
      report_ch.ready <= (rcv_gap == 0);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    logic [7:0]  f[$];
    int          kind;
    int          r;
    logic [31:0] fmt_len;
    logic [15:0] code;
    logic [15:0] chans;
    logic [15:0] bits;
    int          cut;
    int          tail;
    bad_tag_t    bad;

    add_file(32'd16, FMT_PCM, 16'd2, 32'd44100, PCM_BITS, 32'd1000, 2, -1, BAD_NONE, 1'b0);
    add_file(32'd17, FMT_PCM, 16'd1, 32'hFFFF_FFFF, PCM_BITS, 32'hFFFF_FFFF, 1, -1,
             BAD_NONE, 1'b0);
    add_file(32'd16, FMT_PCM, 16'hFFFF, 32'd0, PCM_BITS, 32'd0, 0, -1, BAD_NONE, 1'b1);
    add_file(32'd40, FMT_PCM, 16'd0, 32'd8000, PCM_BITS, 32'd4, 1, -1, BAD_NONE, 1'b0);
    add_file(32'd16, FMT_PCM, 16'd2, 32'd48000, PCM_BITS, 32'd64, 0, 3, BAD_RIFF, 1'b0);
    add_file(32'd16, FMT_PCM, 16'd2, 32'd48000, PCM_BITS, 32'd64, 2, -1, BAD_WAVE, 1'b0);
    add_file(32'd16, FMT_PCM, 16'd2, 32'd48000, PCM_BITS, 32'd64, 2, -1, BAD_FMT, 1'b0);
    add_file(32'd16, FMT_PCM, 16'd2, 32'd48000, PCM_BITS, 32'd64, 2, -1, BAD_DATA, 1'b1);
    add_file(32'd15, FMT_PCM, 16'd2, 32'd22050, PCM_BITS, 32'd64, 1, -1, BAD_NONE, 1'b0);
    add_file(32'd0, FMT_PCM, 16'd2, 32'd22050, PCM_BITS, 32'd64, 1, -1, BAD_NONE, 1'b0);
    add_file(32'd16, 16'h0003, 16'd2, 32'd22050, PCM_BITS, 32'd64, 1, -1, BAD_NONE, 1'b0);
    add_file(32'd16, FMT_PCM, 16'd2, 32'd22050, 16'd24, 32'd64, 1, -1, BAD_NONE, 1'b0);
    add_file(32'd16, 16'hFFFF, 16'd2, 32'd22050, 16'hFFFF, 32'd64, 1, -1, BAD_NONE, 1'b0);
    add_file(32'd16, FMT_PCM, 16'd2, 32'd22050, PCM_BITS, 32'd64, 1, 0, BAD_NONE, 1'b0);
    add_file(32'd16, FMT_PCM, 16'd2, 32'd22050, PCM_BITS, 32'd64, 1, 3, BAD_NONE, 1'b0);
    add_file(32'd16, FMT_PCM, 16'd2, 32'd22050, PCM_BITS, 32'd64, 1, 25, BAD_NONE, 1'b0);
    add_file(32'hFFFF_FFFF, FMT_PCM, 16'd2, 32'd22050, PCM_BITS, 32'd64, 1, -1,
             BAD_NONE, 1'b1);

    while (bytes_queued < 1100) begin
      kind = $urandom_range(0, 9);
      fmt_len = ($urandom_range(0, 3) == 0) ? 32'd16 + $urandom_range(1, 12) : 32'd16;
      code = FMT_PCM;
      bits = PCM_BITS;
      r = $urandom_range(0, 9);
      chans = (r < 7) ? 16'($urandom_range(1, 8)) : (r < 9) ? 16'($urandom) : 16'hFFFF;
      tail = $urandom_range(0, 3);
      cut = -1;
      bad = BAD_NONE;
      case (kind)
        4: if ($urandom_range(0, 2) == 0) chans = 16'd0;
        5: bad = bad_tag_t'($urandom_range(1, 4));
        6: begin
          if ($urandom_range(0, 1) == 0) code = 16'($urandom);
          else bits = 16'($urandom);
        end
        7: cut = $urandom_range(0, 44 + int'(fmt_len) - 16);
        8: fmt_len = ($urandom_range(0, 3) == 0) ? 32'($urandom) : 32'($urandom_range(0, 15));
        default: ;
      endcase
      if (kind == 3 && $urandom_range(0, 1) == 0) begin
        tail = 0;
        cut = 43 + int'(fmt_len) - 16;
      end
      if (kind == 9) begin
        f.delete();
        if ($urandom_range(0, 1) == 0) put_le(f, TAG_RIFF, 4);
        repeat ($urandom_range(1, 12)) f.push_back(8'($urandom));
        push_file(f, 1'b0);
      end else begin
        add_file(fmt_len, code, chans, $urandom, bits, $urandom, tail, cut, bad,
                 $urandom_range(0, 7) == 0);
      end
    end

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    while (file_bytes.size() != 0 || byte_ch.valid) @(posedge clk);
    while (due_reports.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("Streamed %0d bytes in %0d files; checked %0d good and %0d error reports.",
             bytes_taken, files_queued, good_seen, bad_seen);
    if (errors == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
